>>> rtl/nblc_pkg.sv
// Shared types, constants and helpers for the naive Bayes log classifier.
package nblc_pkg;

   localparam int Classes     = 16;
   localparam int Features    = 16;
   localparam int Symbols     = 16;
   localparam int ClassW      = $clog2(Classes);
   localparam int PosW        = $clog2(Features);
   localparam int SymW        = $clog2(Symbols);
   localparam int AddrW       = PosW + SymW;
   localparam int WeightDepth = Features * Symbols;
   localparam int LogW        = 16;
   localparam int ScoreW      = 24;
   localparam int LabelW      = 8;
   localparam int NumClsW     = 5;

   localparam logic [NumClsW-1:0] NumClsReset = 5'd2;

   // request kinds carried in tuser
   localparam logic [1:0] ReqWeight = 2'd0;
   localparam logic [1:0] ReqPrior  = 2'd1;
   localparam logic [1:0] ReqSymbol = 2'd2;

   // running best that walks down the row of cells
   typedef struct packed {
      logic                     vld;
      logic signed [ScoreW-1:0] score;
      logic [ClassW-1:0]        cls;
      logic [LabelW-1:0]        label;
   } token_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic                   weight_we;
      logic                   prior_we;
      logic                   rd_en;
      logic                   start_load;
      logic                   add_en;
      logic                   shift_en;
      logic [ClassW-1:0]      cls;
      logic [AddrW-1:0]       addr;
      logic [LogW-1:0]        value;
      logic [LabelW-1:0]      label;
      logic [NumClsW-1:0]     num_cls;
   } cell_ctl_type;

   // Q8.8 log value sign-extended to score width
   function automatic logic signed [ScoreW-1:0] widen(input logic [LogW-1:0] v);
      widen = {{(ScoreW-LogW){v[LogW-1]}}, v};
   endfunction

endpackage

>>> rtl/nblc_cell.sv
// One class cell: weight memory, prior, label, score and one stage of the argmax chain.
module nblc_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [nblc_pkg::ClassW-1:0]    cell_idx,
   input  nblc_pkg::cell_ctl_type         ctl,
   input  nblc_pkg::token_type            tok_in,
   output nblc_pkg::token_type            tok_out
);

   logic [nblc_pkg::LogW-1:0]          weight_mem [nblc_pkg::WeightDepth];
   logic [nblc_pkg::LogW-1:0]          rd_ff;
   logic [nblc_pkg::LogW-1:0]          prior_ff;
   logic [nblc_pkg::LabelW-1:0]        label_ff;
   logic signed [nblc_pkg::ScoreW-1:0] score_ff, score_in;
   nblc_pkg::token_type                tok_ff, tok_in_nx;
   logic                               sel;
   logic                               takes_part;

   assign sel = (ctl.cls == cell_idx);

   always_ff @(posedge clock) begin
      if (ctl.weight_we && sel) begin
         weight_mem[ctl.addr] <= ctl.value;
      end
      if (ctl.rd_en) begin
         rd_ff <= weight_mem[ctl.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.prior_we && sel) begin
         prior_ff <= ctl.value;
         label_ff <= ctl.label;
      end
   end

   always_comb begin
      score_in = score_ff;
      if (ctl.start_load) begin
         score_in = nblc_pkg::widen(prior_ff);
      end else if (ctl.add_en) begin
         score_in = score_ff + nblc_pkg::widen(rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff <= '0;
      end else begin
         score_ff <= score_in;
      end
   end

   // cell 0 always seeds the best; later cells replace only on strictly greater
   assign takes_part = ({1'b0, cell_idx} < ctl.num_cls);

   always_comb begin
      tok_in_nx = tok_in;
      if ((cell_idx == '0) || (takes_part && (score_ff > tok_in.score))) begin
         tok_in_nx.score = score_ff;
         tok_in_nx.cls   = cell_idx;
         tok_in_nx.label = label_ff;
      end
   end

   // only the valid bit is reset; the payload follows it
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
      end else if (ctl.shift_en) begin
         tok_ff.vld <= tok_in_nx.vld;
      end
      if (ctl.shift_en) begin
         tok_ff.score <= tok_in_nx.score;
         tok_ff.cls   <= tok_in_nx.cls;
         tok_ff.label <= tok_in_nx.label;
      end
   end

   assign tok_out = tok_ff;

endmodule

>>> rtl/naive_bayes_log_classifier.sv
// Top level of the naive Bayes log classifier: sequencer, row of class cells, result register.
//
//  channel | dir | handshake             | carries
//  --------+-----+-----------------------+----------------------------------------------
//  req     | in  | req_tvalid/req_tready | loads and feature symbols, kind in tuser
//  rsp     | out | rsp_tvalid/rsp_tready | label, class index and score of the winner
//  csr     | in  | csr_valid/csr_ready   | num_classes, always ready
//
//  A feature symbol goes through a weight memory read, then an add. After a last symbol
//  the argmax token walks the row of cells and lands in the result register.
//  Reset is synchronous; it clears control, scores and num_classes (to 2). Tables are
//  undefined until loaded.
//  A stalled rsp only holds the token at the end of the row; new loads and symbols are
//  taken once the result sits in the output register.
module naive_bayes_log_classifier (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: class_sel[3:0], feature_pos[7:4], symbol[11:8], log_value[27:12],
   //            class_label[35:28], zero pad [39:36]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [39:0]                         req_tdata,
   // req_tuser: req_type[1:0]
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tlast,
   // rsp_tdata: best_label[7:0], best_class[11:8], best_score[35:12], zero pad [39:36]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [39:0]                         rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nblc_pkg::NumClsW-1:0]        csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADD  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic                            in_sample_ff, in_sample_in;
   logic                            last_ff, last_in;
   logic                            inject_ff, inject_in;
   logic [nblc_pkg::NumClsW-1:0]    num_cls_ff;
   logic                            rsp_vld_ff, rsp_vld_in;
   logic [nblc_pkg::LabelW-1:0]     rsp_label_ff;
   logic [nblc_pkg::ClassW-1:0]     rsp_cls_ff;
   logic [nblc_pkg::ScoreW-1:0]     rsp_score_ff;

   logic                            req_acc;
   logic                            is_weight, is_prior, is_symbol;
   logic                            out_free;
   logic                            capture;
   nblc_pkg::cell_ctl_type          ctl;
   nblc_pkg::token_type             tok [nblc_pkg::Classes+1];
   nblc_pkg::token_type             tail;
   logic [nblc_pkg::Classes-1:0]    tok_vld;

   // request decode
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign is_weight  = req_acc && (req_tuser == nblc_pkg::ReqWeight);
   assign is_prior   = req_acc && (req_tuser == nblc_pkg::ReqPrior);
   assign is_symbol  = req_acc && (req_tuser == nblc_pkg::ReqSymbol);

   // argmax token leaves the last cell
   assign tail     = tok[nblc_pkg::Classes];
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign capture  = (state_ff == ST_SCAN) && tail.vld && out_free;

   // broadcast control to the cells
   always_comb begin
      ctl            = '0;
      ctl.weight_we  = is_weight;
      ctl.prior_we   = is_prior;
      ctl.rd_en      = is_symbol;
      ctl.start_load = is_symbol && !in_sample_ff;
      ctl.add_en     = (state_ff == ST_ADD);
      ctl.shift_en   = (state_ff == ST_SCAN) && !(tail.vld && !out_free);
      ctl.cls        = req_tdata[3:0];
      ctl.addr       = {req_tdata[7:4], req_tdata[11:8]};
      ctl.value      = req_tdata[27:12];
      ctl.label      = req_tdata[35:28];
      ctl.num_cls    = num_cls_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      in_sample_in = in_sample_ff;
      last_in      = last_ff;
      inject_in    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (is_symbol) begin
               state_in     = ST_ADD;
               last_in      = req_tlast;
               in_sample_in = !req_tlast;
            end
         end
         ST_ADD: begin
            if (last_ff) begin
               state_in  = ST_SCAN;
               inject_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (capture) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_sample_ff <= 1'b0;
         last_ff      <= 1'b0;
         inject_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_sample_ff <= in_sample_in;
         last_ff      <= last_in;
         inject_ff    <= inject_in;
      end
   end

   // configuration register; the user writes it only while idle, the block does not enforce this
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cls_ff <= nblc_pkg::NumClsReset;
      end else if (csr_valid && csr_ready) begin
         num_cls_ff <= csr_data;
      end
   end

   // head of the chain: a fresh token on the first scan cycle
   assign tok[0] = '{vld: inject_ff && (state_ff == ST_SCAN), default: '0};

   for (genvar i = 0; i < nblc_pkg::Classes; i++) begin : g_cell
      nblc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (nblc_pkg::ClassW'(i)),
         .ctl      (ctl),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1])
      );
      assign tok_vld[i] = tok[i+1].vld;
   end

   // result register parts the row from the rsp side
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (capture) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         rsp_label_ff <= tail.label;
         rsp_cls_ff   <= tail.cls;
         rsp_score_ff <= tail.score;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0000, rsp_score_ff, rsp_cls_ff, rsp_label_ff};

`ifndef SYNTHESIS
   // at most one argmax token in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_vld) <= 1)
      else $error("more than one argmax token in flight");

   // a token only travels during the scan
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      (tok_vld != '0) |-> (state_ff == ST_SCAN))
      else $error("argmax token outside scan");

   // a symbol that is not last returns to idle after its add
   a_add_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && !last_ff) |=> (state_ff == ST_IDLE))
      else $error("non-last symbol did not return to idle");

   // a finished scan lands in the result register
   a_capture: assert property (@(posedge clock) disable iff (reset)
      capture |=> (rsp_tvalid && state_ff == ST_IDLE && tok_vld == '0))
      else $error("scan result not captured");
`endif

endmodule

>>> tb/tb_naive_bayes_log_classifier.sv
// Testbench for naive_bayes_log_classifier: table loads, scored samples and argmax checks.
`timescale 1ns / 100ps

module tb_naive_bayes_log_classifier;

   // kind code that the block must ignore
   localparam logic [1:0] ReqNoise    = 2'd3;
   localparam int         DrainCycles = 40;     // allowance for the argmax walk
   localparam int         CycleLimit  = 600000;

   typedef struct {
      logic [1:0]                  kind;
      logic [nblc_pkg::ClassW-1:0] cls;
      logic [nblc_pkg::PosW-1:0]   pos;
      logic [nblc_pkg::SymW-1:0]   sym;
      logic [nblc_pkg::LogW-1:0]   value;
      logic [nblc_pkg::LabelW-1:0] label;
      logic                        last;
   } nb_request_type;

   typedef struct {
      logic [nblc_pkg::LabelW-1:0] label;
      logic [nblc_pkg::ClassW-1:0] cls;
      logic [nblc_pkg::ScoreW-1:0] score;
   } nb_verdict_type;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [39:0]                  req_tdata  = '0;
   logic [1:0]                   req_tuser  = '0;
   logic                         req_tlast  = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [39:0]                  rsp_tdata;
   logic                         csr_valid  = 1'b0;
   logic                         csr_ready;
   logic [nblc_pkg::NumClsW-1:0] csr_data   = '0;

   always #6 clock = ~clock;

   naive_bayes_log_classifier u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------------
   // Shadow of the classifier: tables, running scores, open-sample flag and the
   // class count. Updated at the edge where each request transaction is taken.
   // ---------------------------------------------------------------------------
   logic [nblc_pkg::LogW-1:0]   weight_mem [nblc_pkg::Classes][nblc_pkg::WeightDepth];
   logic [nblc_pkg::LogW-1:0]   prior_mem  [nblc_pkg::Classes];
   logic [nblc_pkg::LabelW-1:0] label_mem  [nblc_pkg::Classes];
   logic signed [nblc_pkg::ScoreW-1:0] class_acc [nblc_pkg::Classes] = '{default: '0};
   bit                           sample_open = 1'b0;
   logic [nblc_pkg::NumClsW-1:0] num_cls_reg = nblc_pkg::NumClsReset;

   // Weight addresses are only used by symbols once every class has been loaded
   // there, so the block never reads an unwritten entry.
   bit                          weight_seen [nblc_pkg::Classes][nblc_pkg::WeightDepth];
   bit                          addr_live   [nblc_pkg::WeightDepth];
   int                          live_list[$];

   nb_verdict_type              verdict_q[$];
   int                          err_count   = 0;
   int                          burst_left  = 0;
   int                          cycle_count = 0;

   // Q8.8 log value widened to the score width
   function automatic logic signed [nblc_pkg::ScoreW-1:0] q88_to_score(
      input logic signed [nblc_pkg::LogW-1:0] v);
      q88_to_score = v;
   endfunction

   task automatic score_request(input nb_request_type rq);
      int                                 c;
      int                                 n;
      int                                 best;
      bit                                 full;
      logic [7:0]                         addr;
      logic signed [nblc_pkg::ScoreW-1:0] best_val;
      nb_verdict_type                     v;
      addr = {rq.pos, rq.sym};
      case (rq.kind)
         nblc_pkg::ReqWeight: begin
            weight_mem[rq.cls][addr]  = rq.value;
            weight_seen[rq.cls][addr] = 1'b1;
            if (!addr_live[addr]) begin
               full = 1'b1;
               for (c = 0; c < nblc_pkg::Classes; c++) full &= weight_seen[c][addr];
               if (full) begin
                  addr_live[addr] = 1'b1;
                  live_list.push_back(int'(addr));
               end
            end
         end
         nblc_pkg::ReqPrior: begin
            prior_mem[rq.cls] = rq.value;
            label_mem[rq.cls] = rq.label;
         end
         nblc_pkg::ReqSymbol: begin
            // first symbol of a sample reloads every score from its prior
            if (!sample_open) begin
               for (c = 0; c < nblc_pkg::Classes; c++)
                  class_acc[c] = q88_to_score(prior_mem[c]);
               sample_open = 1'b1;
            end
            for (c = 0; c < nblc_pkg::Classes; c++)
               class_acc[c] = class_acc[c] + q88_to_score(weight_mem[c][addr]);
            if (rq.last) begin
               n = num_cls_reg;
               if (n < 1) n = 1;
               if (n > nblc_pkg::Classes) n = nblc_pkg::Classes;
               // ascending scan, strictly greater wins: ties go to the lower class
               best     = 0;
               best_val = class_acc[0];
               for (c = 1; c < n; c++) begin
                  if (class_acc[c] > best_val) begin
                     best_val = class_acc[c];
                     best     = c;
                  end
               end
               v.label = label_mem[best];
               v.cls   = best[nblc_pkg::ClassW-1:0];
               v.score = class_acc[best];
               verdict_q.push_back(v);
               sample_open = 1'b0;
            end
         end
         default: ;  // unused kind, dropped
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------------------
   function automatic nb_request_type make_request(input logic [1:0] kind, input int cls,
                                                   input int pos, input int sym,
                                                   input logic [nblc_pkg::LogW-1:0] value,
                                                   input logic [nblc_pkg::LabelW-1:0] label,
                                                   input logic last);
      nb_request_type rq;
      rq.kind  = kind;
      rq.cls   = cls[nblc_pkg::ClassW-1:0];
      rq.pos   = pos[nblc_pkg::PosW-1:0];
      rq.sym   = sym[nblc_pkg::SymW-1:0];
      rq.value = value;
      rq.label = label;
      rq.last  = last;
      return rq;
   endfunction

   // log values lean towards the Q8.8 extremes and zero
   function automatic logic [nblc_pkg::LogW-1:0] random_log();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return '0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic nb_request_type random_request(input logic [1:0] kind);
      return make_request(kind, $urandom_range(0, nblc_pkg::Classes-1),
                          $urandom_range(0, nblc_pkg::Features-1),
                          $urandom_range(0, nblc_pkg::Symbols-1), random_log(),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps between them. Valid is
   // left high after a transaction so back-to-back items never drop it.
   // ---------------------------------------------------------------------------
   task automatic push_request(input nb_request_type rq);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= rq.kind;
      req_tlast  <= rq.last;
      req_tdata  <= {4'b0, rq.label, rq.value, rq.sym, rq.pos, rq.cls};
      do @(posedge clock); while (!req_tready);
      score_request(rq);
   endtask

   // Drop valid, let every expected result drain, then allow for the argmax walk
   // of anything still in flight.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_num_classes(input logic [nblc_pkg::NumClsW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      num_cls_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // All priors and labels, plus full weight columns on a 4x4 grid of addresses
   // that toggles every position and symbol bit.
   task automatic test_table_fill();
      int grid[4] = '{0, 5, 10, 15};
      int c;
      int p;
      int s;
      nb_request_type rq;
      for (c = 0; c < nblc_pkg::Classes; c++) begin
         rq     = random_request(nblc_pkg::ReqPrior);
         rq.cls = c[nblc_pkg::ClassW-1:0];
         push_request(rq);
      end
      for (p = 0; p < 4; p++)
         for (s = 0; s < 4; s++)
            for (c = 0; c < nblc_pkg::Classes; c++) begin
               rq     = random_request(nblc_pkg::ReqWeight);
               rq.cls = c[nblc_pkg::ClassW-1:0];
               rq.pos = grid[p][nblc_pkg::PosW-1:0];
               rq.sym = grid[s][nblc_pkg::SymW-1:0];
               push_request(rq);
            end
   endtask

   // Runs at the reset class count of two.
   task automatic test_directed();
      // tie between classes 0 and 1, most negative priors, largest weights
      push_request(make_request(nblc_pkg::ReqPrior,  0,  0,  0, 16'h8000, 8'h00, 1'b0));
      push_request(make_request(nblc_pkg::ReqPrior,  1,  0,  0, 16'h8000, 8'hFF, 1'b0));
      push_request(make_request(nblc_pkg::ReqWeight, 0, 15, 15, 16'h7FFF, 8'h00, 1'b0));
      push_request(make_request(nblc_pkg::ReqWeight, 1, 15, 15, 16'h7FFF, 8'h00, 1'b0));
      push_request(make_request(nblc_pkg::ReqSymbol, 0, 15, 15, 16'h0000, 8'h00, 1'b1));
      // unused kind with every field high, outside a sample
      push_request(make_request(ReqNoise, 15, 15, 15, 16'hFFFF, 8'hFF, 1'b1));
      // loads and noise inside an open sample: weight applies now, prior next time
      push_request(make_request(nblc_pkg::ReqSymbol, 0,  0,  0, 16'h0000, 8'h00, 1'b0));
      push_request(make_request(nblc_pkg::ReqWeight, 1,  0,  0, 16'h7FFF, 8'h00, 1'b0));
      push_request(make_request(nblc_pkg::ReqPrior,  0,  0,  0, 16'h7FFF, 8'hAA, 1'b0));
      push_request(make_request(ReqNoise,  3,  7,  9, 16'h1234, 8'h55, 1'b1));
      push_request(make_request(nblc_pkg::ReqSymbol, 0,  0,  0, 16'h0000, 8'h00, 1'b1));
      // single-symbol sample picking up the new prior
      push_request(make_request(nblc_pkg::ReqSymbol, 0,  5, 10, 16'h0000, 8'h00, 1'b1));
      push_request(make_request(nblc_pkg::ReqPrior, 15,  0,  0, 16'h1234, 8'h5A, 1'b0));
   endtask

   // Long sample pushing class 0 past the positive end and class 1 past the
   // negative end of the 24-bit score.
   task automatic test_score_wrap();
      int i;
      wait_idle();
      write_num_classes(nblc_pkg::NumClsW'(nblc_pkg::Classes));
      push_request(make_request(nblc_pkg::ReqWeight, 0, 10, 5, 16'h7FFF, 8'h00, 1'b0));
      push_request(make_request(nblc_pkg::ReqWeight, 1, 10, 5, 16'h8000, 8'h00, 1'b0));
      for (i = 0; i < 300; i++)
         push_request(make_request(nblc_pkg::ReqSymbol, 0, 10, 5, 16'h0000, 8'h00,
                                   1'b1 && (i == 299)));
   endtask

   // Mostly well-formed samples over loaded addresses, with table updates,
   // loads inside samples and ignored kinds mixed in.
   task automatic run_traffic(input int n_items);
      int             sent;
      int             pick;
      int             len;
      int             i;
      int             c;
      logic [7:0]     a;
      nb_request_type rq;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 11) == 0) begin
                  push_request(random_request($urandom_range(0, 1) ? nblc_pkg::ReqWeight
                                                                   : nblc_pkg::ReqPrior));
                  sent++;
               end else if ($urandom_range(0, 19) == 0) begin
                  push_request(random_request(ReqNoise));
               end
               a       = 8'(live_list[$urandom_range(0, live_list.size() - 1)]);
               rq      = random_request(nblc_pkg::ReqSymbol);
               rq.pos  = a[7:4];
               rq.sym  = a[3:0];
               rq.last = (i == len - 1);
               push_request(rq);
               sent++;
            end
         end else if (pick < 78) begin
            push_request(random_request(nblc_pkg::ReqWeight));
            sent++;
         end else if (pick < 84) begin
            // whole column at a fresh random address, opens it up to symbols
            a = 8'($urandom_range(0, 255));
            for (c = 0; c < nblc_pkg::Classes; c++) begin
               rq     = random_request(nblc_pkg::ReqWeight);
               rq.cls = c[nblc_pkg::ClassW-1:0];
               rq.pos = a[7:4];
               rq.sym = a[3:0];
               push_request(rq);
            end
            sent += nblc_pkg::Classes;
         end else if (pick < 94) begin
            push_request(random_request(nblc_pkg::ReqPrior));
            sent++;
         end else begin
            push_request(random_request(ReqNoise));
         end
      end
   endtask

   // Class count swept across clamped, extreme and random settings.
   task automatic test_random_sweep();
      logic [nblc_pkg::NumClsW-1:0] setting[8] = '{5'd1, 5'd16, 5'd0, 5'd31,
                                                   5'd5, 5'd2, 5'd17, 5'd0};
      int                           k;
      setting[7] = nblc_pkg::NumClsW'($urandom_range(0, 31));
      for (k = 0; k < 8; k++) begin
         wait_idle();
         write_num_classes(setting[k]);
         run_traffic(115);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result side: receiver stalls follow a pattern that changes mode now and then.
   // ---------------------------------------------------------------------------
   int rsp_mode = 0;
   int rsp_left = 0;

   always @(negedge clock) begin
      if (rsp_left == 0) begin
         rsp_mode = $urandom_range(0, 3);
         rsp_left = $urandom_range(20, 300);
      end
      rsp_left--;
      case (rsp_mode)
         0:       rsp_tready <= 1'b1;                           // no stalls
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (rsp_left % 23 == 0);           // long stalls
      endcase
   end

   always @(posedge clock) begin : rsp_check
      nb_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            $error("result transaction with nothing expected: tdata %h", rsp_tdata);
            err_count++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp_tdata[7:0] !== want.label) begin
               $error("best_label mismatch: expected %0d, got %0d", want.label, rsp_tdata[7:0]);
               err_count++;
            end
            if (rsp_tdata[11:8] !== want.cls) begin
               $error("best_class mismatch: expected %0d, got %0d", want.cls, rsp_tdata[11:8]);
               err_count++;
            end
            if (rsp_tdata[35:12] !== want.score) begin
               $error("best_score mismatch: expected %0d, got %0d",
                      $signed(want.score), $signed(rsp_tdata[35:12]));
               err_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_table_fill();
      test_directed();
      test_score_wrap();
      test_random_sweep();
      wait_idle();
      if (err_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> files.f
rtl/nblc_pkg.sv
rtl/nblc_cell.sv
rtl/naive_bayes_log_classifier.sv
tb/tb_naive_bayes_log_classifier.sv
